/* hw/rtl/tdpt_pkg.sv */
// Shared types and constants for the trial-division prime test.
package tdpt_pkg;

  // First trial divisor, step between divisor pairs, gap inside a pair
  localparam int unsigned FIRST_DIV = 5;
  localparam int unsigned DIV_STEP  = 6;
  localparam int unsigned PAIR_GAP  = 2;
  localparam int unsigned SMALL_DIV = 3;
  localparam int unsigned TWO       = 2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV3,
    ST_BOUND,
    ST_DIVA,
    ST_DIVB,
    ST_FINISH
  } tdpt_state_e;

  // Status from the remainder unit
  typedef struct packed {
    logic done;
    logic zero;
  } tdpt_rem_sts_t;

endpackage

/* hw/rtl/tdpt_if.sv */
// Valid/ready channel interfaces for the number word and the result word.
interface tdpt_num_if #(
  parameter int unsigned NUMBER_BITS = 32
);
  logic                   valid;
  logic                   ready;
  logic [NUMBER_BITS-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface tdpt_res_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

/* hw/rtl/tdpt_rem_unit.sv */
// Bit-serial restoring remainder unit: one quotient bit per cycle.
module tdpt_rem_unit
  import tdpt_pkg::*;
#(
  parameter int unsigned NUMBER_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [NUMBER_BITS-1:0] dividend_i,
  input  logic [NUMBER_BITS-1:0] divisor_i,
  output tdpt_rem_sts_t          sts_o
);

  localparam int unsigned CW = $clog2(NUMBER_BITS + 1);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [NUMBER_BITS-1:0] quo_q, quo_d;
  logic [NUMBER_BITS-1:0] rem_q, rem_d;
  logic [NUMBER_BITS-1:0] div_q, div_d;
  logic [NUMBER_BITS:0]   trial;
  logic [NUMBER_BITS:0]   diff;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem_q, quo_q[NUMBER_BITS-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NUMBER_BITS);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = quo_q << 1;
      // Keep the difference when it did not go negative
      if (!diff[NUMBER_BITS]) begin
        rem_d = diff[NUMBER_BITS-1:0];
      end else begin
        rem_d = trial[NUMBER_BITS-1:0];
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign sts_o.done = done_q;
  assign sts_o.zero = (rem_q == '0);

endmodule

/* hw/rtl/trial_division_prime_test.sv */
// Top level: sequencer for the 6k-1 / 6k+1 trial-division prime test.
//
//   port    dir  modport  payload            meaning
//   clk_i   in   -        -                  clock
//   rst_ni  in   -        -                  asynchronous reset, active low
//   num_i   in   sink     number[NB-1:0]     word to test
//   res_o   out  source   is_prime           one result word per number
//
// A number below 4 or even goes from idle straight to finish, where the result register loads.
// Otherwise the sequencer first takes the remainder by 3, then per pair (d, d+2) it runs a
// bound check and two remainders while d*d <= number, stopping early on a zero remainder.
// Reset returns the sequencer to idle and drops any pending result; no clearing pass.
// num_i.ready is high only in idle; a held result stalls the next finish, not input.
module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int unsigned NUMBER_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tdpt_num_if.sink     num_i,
  tdpt_res_if.source   res_o
);

  localparam int unsigned NB = NUMBER_BITS;
  localparam int unsigned SW = 2 * NUMBER_BITS;

  tdpt_state_e    state_q, state_d;
  logic [NB-1:0]  n_q, n_d;
  logic [NB-1:0]  d_q, d_d;
  logic [SW-1:0]  sq_q, sq_d;
  logic           prime_q, prime_d;
  logic           res_vld_q, res_vld_d;
  logic           res_q, res_d;

  logic           rem_start;
  logic [NB-1:0]  rem_dividend;
  logic [NB-1:0]  rem_divisor;
  tdpt_rem_sts_t  rem_sts;
  logic [SW-1:0]  sq_inc;
  logic           slot_free;

  tdpt_rem_unit #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dividend),
    .divisor_i  (rem_divisor),
    .sts_o      (rem_sts)
  );

  // (d+6)^2 - d^2 = 12d + 36
  assign sq_inc = ({{NB{1'b0}}, d_q} * SW'(2 * DIV_STEP)) + SW'(DIV_STEP * DIV_STEP);

  // Dividend comes straight from the input word on the launch out of idle
  assign rem_dividend = (state_q == ST_IDLE) ? num_i.number : n_q;

  assign slot_free = !res_vld_q || res_o.ready;

  // Next state and launch control
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    d_d         = d_q;
    sq_d        = sq_q;
    prime_d     = prime_q;
    rem_start   = 1'b0;
    rem_divisor = NB'(SMALL_DIV);
    unique case (state_q)
      ST_IDLE: begin
        if (num_i.valid) begin
          n_d = num_i.number;
          if (num_i.number < NB'(TWO)) begin
            prime_d = 1'b0;
            state_d = ST_FINISH;
          end else if (num_i.number <= NB'(SMALL_DIV)) begin
            prime_d = 1'b1;
            state_d = ST_FINISH;
          end else if (!num_i.number[0]) begin
            prime_d = 1'b0;
            state_d = ST_FINISH;
          end else begin
            rem_start = 1'b1;
            state_d   = ST_DIV3;
          end
        end
      end
      ST_DIV3: begin
        if (rem_sts.done) begin
          if (rem_sts.zero) begin
            prime_d = 1'b0;
            state_d = ST_FINISH;
          end else begin
            d_d     = NB'(FIRST_DIV);
            sq_d    = SW'(FIRST_DIV * FIRST_DIV);
            state_d = ST_BOUND;
          end
        end
      end
      ST_BOUND: begin
        // Stop once the divisor squared passes the number
        if (sq_q > {{NB{1'b0}}, n_q}) begin
          prime_d = 1'b1;
          state_d = ST_FINISH;
        end else begin
          rem_start   = 1'b1;
          rem_divisor = d_q;
          state_d     = ST_DIVA;
        end
      end
      ST_DIVA: begin
        rem_divisor = d_q + NB'(PAIR_GAP);
        if (rem_sts.done) begin
          if (rem_sts.zero) begin
            prime_d = 1'b0;
            state_d = ST_FINISH;
          end else begin
            rem_start = 1'b1;
            state_d   = ST_DIVB;
          end
        end
      end
      ST_DIVB: begin
        if (rem_sts.done) begin
          if (rem_sts.zero) begin
            prime_d = 1'b0;
            state_d = ST_FINISH;
          end else begin
            d_d     = d_q + NB'(DIV_STEP);
            sq_d    = sq_q + sq_inc;
            state_d = ST_BOUND;
          end
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result register: load on finish, drop when taken
  always_comb begin
    res_vld_d = res_vld_q;
    res_d     = res_q;
    if (res_vld_q && res_o.ready) begin
      res_vld_d = 1'b0;
    end
    if (state_q == ST_FINISH && slot_free) begin
      res_vld_d = 1'b1;
      res_d     = prime_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    d_q     <= d_d;
    sq_q    <= sq_d;
    prime_q <= prime_d;
    res_q   <= res_d;
  end

  assign num_i.ready    = (state_q == ST_IDLE);
  assign res_o.valid    = res_vld_q;
  assign res_o.is_prime = res_q;

endmodule
